FILE: sv/ifp_pkg.sv
// shared widths, codes, types and helpers of the imu position fusion block
package ifp_pkg;

	// serial multiplier operand width and product width
	localparam int MUL_W = 34;
	localparam int PROD_W = 2 * MUL_W;

	// serial divider: numerator is |diff| << 16, denominator is dt
	localparam int DIV_NUM_W = 49;
	localparam int DIV_DEN_W = 32;

	localparam int WGT_W = 17;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 17;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SCALE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_W_ACCEL     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_W_GYRO      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_W_MERGE     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_W_POS_VEL   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_W_POS_SENS  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_W_HEADING   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_W_VEL       = 4'd7;

	// slots of the weight register array
	localparam logic [2:0] WI_ACCEL    = 3'd0;
	localparam logic [2:0] WI_GYRO     = 3'd1;
	localparam logic [2:0] WI_MERGE    = 3'd2;
	localparam logic [2:0] WI_POS_VEL  = 3'd3;
	localparam logic [2:0] WI_POS_SENS = 3'd4;
	localparam logic [2:0] WI_HEADING  = 3'd5;
	localparam logic [2:0] WI_VEL      = 3'd6;

	// sequencer program: steps 0..15 are eight per axis, then heading and velocity
	localparam logic [4:0] OP_HEADING = 5'd16;
	localparam logic [4:0] OP_DIV_X   = 5'd17;
	localparam logic [4:0] OP_VEL_X   = 5'd18;
	localparam logic [4:0] OP_DIV_Y   = 5'd19;
	localparam logic [4:0] OP_VEL_Y   = 5'd20;
	localparam logic [4:0] OP_LAST    = OP_VEL_Y;

	typedef enum logic [2:0] {
		K_A_UP,
		K_G_UP,
		K_FA,
		K_FG,
		K_SENSOR,
		K_V_UP,
		K_POS_VEL,
		K_POS_SENS
	} step_t;

	typedef enum logic [2:0] {
		D_T0,
		D_T1,
		D_FA,
		D_FG,
		D_POS,
		D_VEL
	} dest_t;

	typedef struct packed {
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
		logic signed [31:0]      base;
		logic                    rnd;
		logic                    is_div;
		dest_t                   dest;
		logic [1:0]              ax;
	} uop_t;

	function automatic logic signed [31:0] sat32(input logic signed [69:0] x);
		if (x > 70'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -70'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return $signed(x[31:0]);
		end
	endfunction

endpackage

FILE: sv/ifp_stream_if.sv
// valid/ready channels for imu samples and fused estimates
interface ifp_in_if;
	logic               valid;
	logic               ready;
	logic [31:0]        time_stamp;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;

	modport source (output valid, time_stamp, accel_x, accel_y, gyro_x, gyro_y, gyro_z,
		input ready);
	modport sink (input valid, time_stamp, accel_x, accel_y, gyro_x, gyro_y, gyro_z,
		output ready);
endinterface

interface ifp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] heading;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic               skipped;

	modport source (output valid, pos_x, pos_y, heading, vel_x, vel_y, skipped,
		input ready);
	modport sink (input valid, pos_x, pos_y, heading, vel_x, vel_y, skipped,
		output ready);
endinterface

FILE: sv/ifp_mul.sv
// bit-serial signed multiplier, one bit of b per cycle
module ifp_mul
	import ifp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic                     done,
	output logic signed [PROD_W-1:0] p
);

	localparam int CNT_W = $clog2(MUL_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic signed [MUL_W:0]   a_q;
	logic signed [MUL_W:0]   hi_q;
	logic [MUL_W-1:0]        lo_q;
	logic              last;
	logic signed [MUL_W:0]   addend;
	logic signed [MUL_W:0]   sum;

	assign last = (cnt_q == CNT_W'(MUL_W - 1));

	// top bit of b carries negative weight
	always_comb begin
		if (lo_q[0]) begin
			addend = last ? -a_q : a_q;
		end else begin
			addend = '0;
		end
		sum = hi_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= {a[MUL_W-1], a};
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= {sum[MUL_W], sum[MUL_W:1]};
			lo_q <= {sum[0], lo_q[MUL_W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = $signed({hi_q[MUL_W-1:0], lo_q});

endmodule

FILE: sv/ifp_div.sv
// restoring unsigned divider, one quotient bit per cycle
module ifp_div
	import ifp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] q
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	always_comb begin
		trial = {rem_q, quo_q[DIV_NUM_W-1]};
		ge    = (trial >= {1'b0, den_q});
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign q    = quo_q;

endmodule

FILE: sv/imu_position_fusion_top.sv
// imu position fusion: complementary filter sequenced over a serial multiplier and divider
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    time_stamp, accel_x/y, gyro_x/y/z
//   out_ch   out  valid/ready    pos_x, pos_y, heading, vel_x, vel_y, skipped
//   cfg      in   cfg_we         cfg_index, cfg_data (no read-back)
//
// a sample that advances time runs 19 multiplies in the shared bit-serial
// multiplier and 2 divides in the serial divider, plus a few sequencing states.
// a skipped sample (first one, or time not advancing) goes straight to the output state.
// one sample is in work at a time; in_ch.ready is high only when idle.
// the result sits in an output register, so a new sample is taken while it waits.
// arst_n clears estimates, last time and configuration to their reset values.
module imu_position_fusion_top
	import ifp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	ifp_in_if.sink                in_ch,
	ifp_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_LOAD    = 7'b0000010,
		S_MUL     = 7'b0000100,
		S_POST    = 7'b0001000,
		S_DIV     = 7'b0010000,
		S_DIVPOST = 7'b0100000,
		S_OUT     = 7'b1000000
	} state_t;

	state_t state_q;
	logic [4:0] op_q;

	// configuration
	logic signed [15:0] scale_q;
	logic [WGT_W-1:0]   w_q [7];

	// filter state
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [2];
	logic signed [31:0] fa_q [2];
	logic signed [31:0] fg_q [2];
	logic [31:0]        last_q;

	// per-sample working registers
	logic signed [15:0] ax_q, ay_q, gx_q, gy_q, gz_q;
	logic [31:0]        dt_q;
	logic signed [31:0] old_q [2];
	logic signed [31:0] t0_q, t1_q;
	logic               skip_q;
	logic               neg_q;
	uop_t               uop_q;

	// output register
	logic               ov_q;
	logic signed [31:0] o_pos_x_q, o_pos_y_q, o_head_q, o_vel_x_q, o_vel_y_q;
	logic               o_skip_q;

	logic in_xfer;
	logic skip_now;
	logic out_load;
	uop_t uop;
	logic ax1;

	logic                     mul_start, mul_done;
	logic signed [PROD_W-1:0] mul_p;
	logic                     div_start, div_done;
	logic [DIV_NUM_W-1:0]     div_num, div_q;
	logic signed [32:0]       vdiff;
	logic [32:0]              vmag;

	logic signed [68:0] p_rnd, p_sel;
	logic signed [69:0] post_sum;
	logic signed [31:0] post_res;
	logic signed [49:0] q_signed;
	logic signed [31:0] meas;

	function automatic uop_t mk_blend(input logic signed [31:0] m1,
		input logic signed [31:0] m2, input logic [WGT_W-1:0] w,
		input dest_t dst, input logic [1:0] ax);
		uop_t u;
		logic signed [32:0] d;
		logic [WGT_W-1:0] wc;
		d = $signed({m2[31], m2} - {m1[31], m1});
		// weights above one act as one
		wc = w[16] ? 17'h10000 : w;
		u.a = {d[32], d};
		u.b = $signed({17'b0, wc});
		u.base = m1;
		u.rnd = 1'b1;
		u.is_div = 1'b0;
		u.dest = dst;
		u.ax = ax;
		return u;
	endfunction

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign skip_now = (last_q == 32'd0) || (last_q >= in_ch.time_stamp);
	assign out_load = (state_q == S_OUT) && (!ov_q || out_ch.ready);
	assign ax1      = op_q[3];

	// micro-op decode of the current program step
	always_comb begin
		logic signed [15:0] acc, gyr;
		acc = ax1 ? ay_q : ax_q;
		gyr = ax1 ? gy_q : gx_q;
		uop = '0;
		if (op_q < OP_HEADING) begin
			unique case (step_t'(op_q[2:0]))
				K_A_UP: begin
					// raw accel times Q8.8 scale, shifted up into Q16.16
					uop.a = $signed({{10{acc[15]}}, acc, 8'b0});
					uop.b = $signed({{18{scale_q[15]}}, scale_q});
					uop.dest = D_T0;
				end
				K_G_UP: begin
					uop.a = $signed({{18{gyr[15]}}, gyr});
					uop.b = $signed({2'b0, dt_q});
					uop.base = pos_q[{1'b0, ax1}];
					uop.dest = D_T1;
				end
				K_FA: uop = mk_blend(fa_q[ax1], t0_q, w_q[WI_ACCEL], D_FA, {1'b0, ax1});
				K_FG: uop = mk_blend(fg_q[ax1], t1_q, w_q[WI_GYRO], D_FG, {1'b0, ax1});
				K_SENSOR: uop = mk_blend(fa_q[ax1], fg_q[ax1], w_q[WI_MERGE], D_T0,
					{1'b0, ax1});
				K_V_UP: begin
					uop.a = $signed({{2{vel_q[ax1][31]}}, vel_q[ax1]});
					uop.b = $signed({2'b0, dt_q});
					uop.base = pos_q[{1'b0, ax1}];
					uop.rnd = 1'b1;
					uop.dest = D_T1;
				end
				K_POS_VEL: uop = mk_blend(pos_q[{1'b0, ax1}], t1_q, w_q[WI_POS_VEL],
					D_POS, {1'b0, ax1});
				K_POS_SENS: uop = mk_blend(pos_q[{1'b0, ax1}], t0_q, w_q[WI_POS_SENS],
					D_POS, {1'b0, ax1});
				default: uop = '0;
			endcase
		end else begin
			priority case (op_q)
				OP_HEADING: uop = mk_blend(pos_q[2], $signed({gz_q, 16'b0}),
					w_q[WI_HEADING], D_POS, 2'd2);
				OP_DIV_X: begin
					uop.is_div = 1'b1;
					uop.dest = D_T0;
					uop.ax = 2'd0;
				end
				OP_VEL_X: uop = mk_blend(vel_q[0], t0_q, w_q[WI_VEL], D_VEL, 2'd0);
				OP_DIV_Y: begin
					uop.is_div = 1'b1;
					uop.dest = D_T0;
					uop.ax = 2'd1;
				end
				OP_VEL_Y: uop = mk_blend(vel_q[1], t0_q, w_q[WI_VEL], D_VEL, 2'd1);
				default: uop = '0;
			endcase
		end
	end

	// divider operands: |pos_new - pos_old| << 16 over dt
	always_comb begin
		vdiff = $signed({pos_q[uop.ax][31], pos_q[uop.ax]}
			- {old_q[uop.ax[0]][31], old_q[uop.ax[0]]});
		vmag = vdiff[32] ? 33'(-vdiff) : 33'(vdiff);
		div_num = {vmag, 16'b0};
	end

	assign mul_start = (state_q == S_LOAD) && !uop.is_div;
	assign div_start = (state_q == S_LOAD) && uop.is_div;

	ifp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (uop.a),
		.b      (uop.b),
		.done   (mul_done),
		.p      (mul_p)
	);

	ifp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (dt_q),
		.done   (div_done),
		.q      (div_q)
	);

	// product post-processing: optional round to Q16.16, add base, saturate
	always_comb begin
		p_rnd = ($signed({mul_p[PROD_W-1], mul_p}) + 69'sd32768) >>> 16;
		p_sel = uop_q.rnd ? p_rnd : 69'(mul_p);
		post_sum = 70'($signed(uop_q.base)) + 70'(p_sel);
		post_res = sat32(post_sum);
		// quotient truncates toward zero, sign applied afterwards
		q_signed = neg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
		meas = sat32(70'(q_signed));
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						op_q    <= '0;
						state_q <= skip_now ? S_OUT : S_LOAD;
					end
				end
				S_LOAD: state_q <= uop.is_div ? S_DIV : S_MUL;
				S_MUL: begin
					if (mul_done) begin
						state_q <= S_POST;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DIVPOST;
					end
				end
				S_POST, S_DIVPOST: begin
					op_q    <= op_q + 5'd1;
					state_q <= (op_q == OP_LAST) ? S_OUT : S_LOAD;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// configuration registers and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 16'sd256;
			for (int i = 0; i < 7; i++) begin
				w_q[i] <= 17'd32768;
			end
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				vel_q[i] <= '0;
				fa_q[i]  <= '0;
				fg_q[i]  <= '0;
			end
			last_q <= '0;
		end else begin
			if (cfg_we) begin
				priority if (cfg_index == CFG_ACCEL_SCALE) begin
					scale_q <= $signed(cfg_data[15:0]);
				end else if (cfg_index <= CFG_W_VEL) begin
					w_q[3'(cfg_index - CFG_W_ACCEL)] <= cfg_data;
				end
			end
			if (in_xfer) begin
				last_q <= in_ch.time_stamp;
			end
			if (state_q == S_POST) begin
				unique case (uop_q.dest)
					D_FA:    fa_q[uop_q.ax[0]]  <= post_res;
					D_FG:    fg_q[uop_q.ax[0]]  <= post_res;
					D_POS:   pos_q[uop_q.ax]    <= post_res;
					D_VEL:   vel_q[uop_q.ax[0]] <= post_res;
					default: ;
				endcase
			end
		end
	end

	// sample capture, temporaries and output payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ax_q     <= in_ch.accel_x;
			ay_q     <= in_ch.accel_y;
			gx_q     <= in_ch.gyro_x;
			gy_q     <= in_ch.gyro_y;
			gz_q     <= in_ch.gyro_z;
			dt_q     <= in_ch.time_stamp - last_q;
			old_q[0] <= pos_q[0];
			old_q[1] <= pos_q[1];
			skip_q   <= skip_now;
		end
		if (state_q == S_LOAD) begin
			uop_q <= uop;
			neg_q <= vdiff[32];
		end
		if (state_q == S_POST) begin
			if (uop_q.dest == D_T0) begin
				t0_q <= post_res;
			end
			if (uop_q.dest == D_T1) begin
				t1_q <= post_res;
			end
		end
		if (state_q == S_DIVPOST) begin
			t0_q <= meas;
		end
		if (out_load) begin
			o_pos_x_q <= pos_q[0];
			o_pos_y_q <= pos_q[1];
			o_head_q  <= pos_q[2];
			o_vel_x_q <= vel_q[0];
			o_vel_y_q <= vel_q[1];
			o_skip_q  <= skip_q;
		end
	end

	assign out_ch.valid   = ov_q;
	assign out_ch.pos_x   = o_pos_x_q;
	assign out_ch.pos_y   = o_pos_y_q;
	assign out_ch.heading = o_head_q;
	assign out_ch.vel_x   = o_vel_x_q;
	assign out_ch.vel_y   = o_vel_y_q;
	assign out_ch.skipped = o_skip_q;

endmodule

FILE: sv/ifp_checker.sv
// port-level checks of the imu position fusion block, bound to the top level
module ifp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pos_x,
	input logic [31:0] vel_x,
	input logic        skipped
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	// a held result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pos_x) && $stable(vel_x) && $stable(skipped))
		else $error("result payload changed while stalled");

	// one sample at a time: busy right after a transfer in
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second sample taken while first in work");

	// a result never appears the cycle right after its sample
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind imu_position_fusion_top ifp_checker u_ifp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.pos_x     (out_ch.pos_x),
	.vel_x     (out_ch.vel_x),
	.skipped   (out_ch.skipped)
);

FILE: bench/fusion_checker.sv
// fusion estimate checker: predicts each estimate from the accepted samples and compares
module fusion_checker
	import ifp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	ifp_in_if                     in_ch,
	ifp_out_if                    out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);

	typedef struct {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] heading;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic               skipped;
	} fusion_est_t;

	fusion_est_t est_q[$];

	longint     scale_q88;
	logic [16:0] wgt[7];
	logic signed [31:0] pos_est[3];
	logic signed [31:0] vel_est[2];
	logic signed [31:0] acc_filt[2];
	logic signed [31:0] gyr_filt[2];
	logic [31:0] prev_stamp;

	function automatic logic signed [31:0] clamp32(longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	// m1 + w*(m2-m1), weight clamped to one, rounded by floor(x + 1/2)
	function automatic logic signed [31:0] mix(logic signed [31:0] m1, logic signed [31:0] m2,
		logic [16:0] w);
		longint d;
		longint ww;
		d = longint'(m2) - longint'(m1);
		ww = (w > 17'd65536) ? 64'd65536 : longint'(w);
		return clamp32(longint'(m1) + ((d * ww + 32768) >>> 16));
	endfunction

	function automatic fusion_est_t fuse(logic [31:0] t, logic signed [15:0] ax,
		logic signed [15:0] ay, logic signed [15:0] gx, logic signed [15:0] gy,
		logic signed [15:0] gz);
		fusion_est_t r;
		longint dt;
		longint acc[2];
		longint gyr[2];
		logic signed [31:0] old[2];
		logic signed [31:0] sensor;
		logic signed [31:0] a_up;
		logic signed [31:0] g_up;
		logic signed [31:0] v_up;
		logic signed [31:0] meas;
		r.skipped = 1'b0;
		acc[0] = longint'(ax);
		acc[1] = longint'(ay);
		gyr[0] = longint'(gx);
		gyr[1] = longint'(gy);
		if (prev_stamp == 32'd0 || prev_stamp >= t) begin
			prev_stamp = t;
			r.skipped = 1'b1;
		end else begin
			dt = longint'(t) - longint'(prev_stamp);
			for (int i = 0; i < 2; i++) begin
				a_up = clamp32(acc[i] * scale_q88 * 256);
				g_up = clamp32(longint'(pos_est[i]) + gyr[i] * dt);
				old[i] = pos_est[i];
				acc_filt[i] = mix(acc_filt[i], a_up, wgt[WI_ACCEL]);
				gyr_filt[i] = mix(gyr_filt[i], g_up, wgt[WI_GYRO]);
				sensor = mix(acc_filt[i], gyr_filt[i], wgt[WI_MERGE]);
				v_up = clamp32(longint'(pos_est[i]) + ((longint'(vel_est[i]) * dt + 32768) >>> 16));
				pos_est[i] = mix(pos_est[i], v_up, wgt[WI_POS_VEL]);
				pos_est[i] = mix(pos_est[i], sensor, wgt[WI_POS_SENS]);
			end
			pos_est[2] = mix(pos_est[2], clamp32(longint'(gz) * 65536), wgt[WI_HEADING]);
			for (int i = 0; i < 2; i++) begin
				// signed division truncates toward zero
				meas = clamp32(((longint'(pos_est[i]) - longint'(old[i])) * 65536) / dt);
				vel_est[i] = mix(vel_est[i], meas, wgt[WI_VEL]);
			end
			prev_stamp = t;
		end
		r.pos_x = pos_est[0];
		r.pos_y = pos_est[1];
		r.heading = pos_est[2];
		r.vel_x = vel_est[0];
		r.vel_y = vel_est[1];
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	assign pending = est_q.size();

	always @(posedge clk or negedge arst_n) begin
		fusion_est_t want;
		if (!arst_n) begin
			errors = 0;
			est_q.delete();
			scale_q88 = 256;
			for (int i = 0; i < 7; i++) wgt[i] = 17'd32768;
			for (int i = 0; i < 3; i++) pos_est[i] = '0;
			for (int i = 0; i < 2; i++) begin
				vel_est[i] = '0;
				acc_filt[i] = '0;
				gyr_filt[i] = '0;
			end
			prev_stamp = '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ACCEL_SCALE)
					scale_q88 = longint'($signed(cfg_data[15:0]));
				else if (cfg_index <= CFG_W_VEL)
					wgt[3'(cfg_index - CFG_W_ACCEL)] = cfg_data;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (est_q.size() == 0) begin
					$display("estimate transfer with nothing expected");
					errors++;
				end else begin
					want = est_q.pop_front();
					if (out_ch.pos_x !== want.pos_x) report("pos_x", out_ch.pos_x, want.pos_x);
					if (out_ch.pos_y !== want.pos_y) report("pos_y", out_ch.pos_y, want.pos_y);
					if (out_ch.heading !== want.heading)
						report("heading", out_ch.heading, want.heading);
					if (out_ch.vel_x !== want.vel_x) report("vel_x", out_ch.vel_x, want.vel_x);
					if (out_ch.vel_y !== want.vel_y) report("vel_y", out_ch.vel_y, want.vel_y);
					if (out_ch.skipped !== want.skipped)
						report("skipped", 32'(out_ch.skipped), 32'(want.skipped));
				end
			end
			if (in_ch.valid && in_ch.ready)
				est_q.push_back(fuse(in_ch.time_stamp, in_ch.accel_x, in_ch.accel_y,
					in_ch.gyro_x, in_ch.gyro_y, in_ch.gyro_z));
		end
	end

endmodule

FILE: bench/tb_imu_position_fusion_top.sv
// testbench top: sample stimulus, configuration phases, output stalls and verdict
module tb_imu_position_fusion_top;
	import ifp_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors;
	int                    pending;
	int                    cycles;
	bit                    long_hold_req;
	logic [31:0]           stamp;

	ifp_in_if  in_ch();
	ifp_out_if out_ch();

	imu_position_fusion_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	fusion_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// global watchdog: several times the slowest correct run including stalls
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 4000000) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side: random ready pattern, plus one long hold to back the block up
	initial begin
		int on_len;
		int off_len;
		out_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end else begin
				on_len = $urandom_range(0, 12);
				off_len = pick_gap();
				out_ch.ready <= 1'b1;
				repeat (on_len + 1) @(posedge clk);
				if (off_len > 0) begin
					out_ch.ready <= 1'b0;
					repeat (off_len) @(posedge clk);
				end
			end
		end
	end

	// offer one sample and hold it until the transfer, then maybe back off
	task automatic send_sample(logic [31:0] t, logic [15:0] ax, logic [15:0] ay,
		logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.time_stamp <= t;
		in_ch.accel_x <= ax;
		in_ch.accel_y <= ay;
		in_ch.gyro_x <= gx;
		in_ch.gyro_y <= gy;
		in_ch.gyro_z <= gz;
		do @(posedge clk); while (!in_ch.ready);
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// drain everything in flight so registers change only while idle
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// per phase weight style: 0 random, 1 all one, 2 all zero, 3 above one
	task automatic load_phase(int style);
		logic [CFG_DATA_W-1:0] w;
		case (style)
			1: write_reg(CFG_ACCEL_SCALE, 17'h07fff);
			2: write_reg(CFG_ACCEL_SCALE, 17'h08000);
			3: write_reg(CFG_ACCEL_SCALE, 17'h00000);
			default: write_reg(CFG_ACCEL_SCALE, CFG_DATA_W'($urandom));
		endcase
		for (int i = CFG_W_ACCEL; i <= CFG_W_VEL; i++) begin
			case (style)
				1: w = 17'd65536;
				2: w = 17'd0;
				3: w = 17'h1ffff;
				default: w = ($urandom_range(0, 9) == 0) ? 17'd65536 :
					CFG_DATA_W'($urandom_range(0, 65535));
			endcase
			write_reg(CFG_IDX_W'(i), w);
		end
		// an index past the last register must be ignored
		write_reg(CFG_IDX_W'($urandom_range(8, 15)), CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random sample: mostly time moving forward by a small step, with some noise
	task automatic random_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 82) stamp = stamp + $urandom_range(1, 40000);
		else if (r < 88) stamp = stamp - $urandom_range(0, 3);
		else if (r < 92) stamp = '0;
		else if (r < 95) stamp = stamp + $urandom_range(40000, 2000000);
		else stamp = $urandom;
		send_sample(stamp, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		long_hold_req = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.time_stamp = '0;
		in_ch.accel_x = '0;
		in_ch.accel_y = '0;
		in_ch.gyro_x = '0;
		in_ch.gyro_y = '0;
		in_ch.gyro_z = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero stamps, first sample, field extremes, stalled and backward time
		send_sample(32'h0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		send_sample(32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
		send_sample(32'h10000, 16'h1234, 16'h4321, 16'h0010, 16'hfff0, 16'h0005);
		send_sample(32'h18000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_sample(32'h20000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_sample(32'h20000, 16'h0100, 16'h0100, 16'h0001, 16'h0001, 16'h0001);
		send_sample(32'h1ffff, 16'h0100, 16'h0100, 16'h0001, 16'h0001, 16'h0001);
		send_sample(32'h20001, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_sample(32'h20002, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(32'h7fff0000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
		send_sample(32'hffffffff, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
		send_sample(32'h00000001, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
		send_sample(32'h00000002, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		stamp = 32'h2;

		// phases: reset config, then all one, all zero, above one, then random settings
		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0) begin
				settle();
				load_phase(ph <= 3 ? ph : 0);
			end
			for (int n = 0; n < 120; n++) begin
				if (ph == 2 && n == 30) long_hold_req = 1'b1;
				random_sample();
			end
		end

		settle();
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
